// ===== rtl/pit_pkg.sv =====
// Shared types and constants for the periodic interval timer.
// No dependencies; imported by the interfaces, pit_core and the top level.
package pit_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PERIOD_W = 12;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } pit_op_e;

  localparam logic [ADDR_W-1:0] ADDR_MODE   = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_VALUE  = 4'h8;
  localparam logic [ADDR_W-1:0] ADDR_IMAGE  = 4'hc;

  localparam logic [DATA_W-1:0] MODE_RESET = 32'h000f_ffff;
  localparam int unsigned       EN_BIT     = 24;
  localparam int unsigned       IRQ_EN_BIT = 25;

  typedef struct packed {
    pit_op_e             op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
  } pit_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                irq;
  } pit_rsp_t;

endpackage

// ===== rtl/pit_if.sv =====
// Valid/ready channel interfaces for the timer's request and response words.
// Depends on pit_pkg for field widths.
interface pit_req_if;
  logic                        valid;
  logic                        ready;
  logic [pit_pkg::OP_W-1:0]    operation;
  logic [pit_pkg::ADDR_W-1:0]  address;
  logic [pit_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface pit_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pit_pkg::DATA_W-1:0]  read_data;
  logic                        irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink   (input valid, input read_data, input irq, output ready);
endinterface

// ===== rtl/periodic_interval_timer.sv =====
// Top level of the periodic interval timer: input register, core, result register.
// Depends on pit_pkg, pit_if (pit_req_if, pit_rsp_if) and pit_core.
//
// Usage:
//   req_i carries one word per item: a tick of the prescaled clock, a register
//   read or a register write (operation, address, write_data). rsp_o returns
//   exactly one word per request, in order: read_data (zero for ticks and
//   writes) and irq, the interrupt level after that request.
//   Path: a response word passes through the input register and then the
//   result register; it can wait in the input register while rsp_o is held.
//   Throughput: one request per cycle while rsp_o is not held; all state
//   updates in a single pass through pit_core between the two registers.
//   Reset: mode reads 0x000fffff, the timer is stopped, status, period count,
//   current value and irq are zero, and both registers are empty.
//   Stall: while rsp_o is held, the result register keeps its word and the
//   input register absorbs one more request; req_i.ready drops only when both
//   are full.
module periodic_interval_timer #(
  parameter int unsigned VALUE_WIDTH = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pit_req_if.sink   req_i,
  pit_rsp_if.source rsp_o
);
  import pit_pkg::*;

  logic     in_valid_q;
  pit_req_t in_word_q;
  logic     out_valid_q;
  pit_rsp_t out_word_q;
  pit_rsp_t core_rsp;
  logic     advance;
  logic     in_take;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q.op    <= pit_op_e'(req_i.operation);
      in_word_q.addr  <= req_i.address;
      in_word_q.wdata <= req_i.write_data;
    end
  end

  pit_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_word_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_word_q <= core_rsp;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_word_q.read_data;
  assign rsp_o.irq       = out_word_q.irq;

`ifndef NO_ASSERTIONS
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word did not reach result register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> in_valid_q && out_valid_q && !rsp_o.ready)
    else $error("request stalled with room available");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_word_q))
    else $error("result word dropped while stalled");
`endif

endmodule

// ===== rtl/pit_core.sv =====
// Timer state registers and the single-pass update for one request word.
// Depends on pit_pkg; instantiated by periodic_interval_timer.
module pit_core #(
  parameter int unsigned VALUE_WIDTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  pit_pkg::pit_req_t req_i,
  output pit_pkg::pit_rsp_t rsp_o
);
  import pit_pkg::*;

  logic [DATA_W-1:0]      mode_q, mode_d;
  logic                   status_q, status_d;
  logic [PERIOD_W-1:0]    period_q, period_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   run_q, run_d;
  logic                   irq_q, irq_d;

  logic [VALUE_WIDTH-1:0] interval;
  logic [DATA_W-1:0]      image;

  assign interval = mode_q[VALUE_WIDTH-1:0];
  assign image    = DATA_W'({period_q, value_q});

  always_comb begin
    mode_d          = mode_q;
    status_d        = status_q;
    period_d        = period_q;
    value_d         = value_q;
    run_d           = run_q;
    irq_d           = irq_q;
    rsp_o.read_data = '0;
    if (en_i) begin
      unique case (req_i.op)
        OP_TICK: begin
          if (run_q) begin
            if (value_q >= interval) begin
              // end of period: wrap and flag it
              value_d  = '0;
              status_d = 1'b1;
              period_d = period_q + 1'b1;
              if (mode_q[IRQ_EN_BIT]) irq_d = 1'b1;
            end else begin
              value_d = value_q + 1'b1;
            end
          end
        end
        OP_READ: begin
          unique case (req_i.addr)
            ADDR_MODE:   rsp_o.read_data = mode_q;
            ADDR_STATUS: rsp_o.read_data = DATA_W'(status_q);
            ADDR_VALUE: begin
              // acknowledge the period; return the word as it stood
              rsp_o.read_data = image;
              status_d        = 1'b0;
              period_d        = '0;
              irq_d           = 1'b0;
            end
            ADDR_IMAGE:  rsp_o.read_data = image;
            default:     rsp_o.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          if (req_i.addr == ADDR_MODE) begin
            mode_d  = req_i.wdata;
            value_d = '0;
            run_d   = req_i.wdata[EN_BIT];
          end
        end
        default: ;
      endcase
    end
    rsp_o.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      status_q <= 1'b0;
      period_q <= '0;
      value_q  <= '0;
      run_q    <= 1'b0;
      irq_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      status_q <= status_d;
      period_q <= period_d;
      value_q  <= value_d;
      run_q    <= run_d;
      irq_q    <= irq_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_q <= interval)
    else $error("current value above interval");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(irq_q) && $stable(value_q) && $stable(period_q))
    else $error("state changed without a word");

  a_irq_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(mode_q[IRQ_EN_BIT]))
    else $error("interrupt raised while disabled");
`endif

endmodule
